/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of aclk, suspended while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every rising edge of aclk, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* hw/rtl/gfsr_pkg.sv */
package gfsr_pkg;

    localparam int unsigned FAN_W   = 8;
    localparam int unsigned TEMP_W  = 8;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned CARD_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [HOUR_W-1:0] DAY_START_HOUR   = 5'd10;
    localparam logic [HOUR_W-1:0] NIGHT_START_HOUR = 5'd22;

    localparam logic [FAN_W-1:0] FAN_MAX   = 8'd255;
    localparam logic [FAN_W-1:0] FAN_RESET = 8'd200;
    localparam logic signed [TEMP_W:0] ERR_FLOOR = -9'sd4;
    localparam logic [TEMP_W:0] BOOST_THRESHOLD  = 9'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DAY_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_MIN_FAN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_MIN_FAN  = 3'd4;

    localparam logic signed [TEMP_W-1:0] DAY_LIMIT_RESET      = 8'sd75;
    localparam logic signed [TEMP_W-1:0] NIGHT_LIMIT_RESET    = 8'sd70;
    localparam logic signed [TEMP_W-1:0] CRITICAL_LIMIT_RESET = 8'sd85;
    localparam logic [FAN_W-1:0] DAY_MIN_FAN_RESET   = 8'd100;
    localparam logic [FAN_W-1:0] NIGHT_MIN_FAN_RESET = 8'd100;

    typedef struct packed {
        logic [HOUR_W-1:0]        hour;
        logic signed [TEMP_W-1:0] temperature;
        logic [CARD_W-1:0]        card_index;
    } sample_t;

    typedef struct packed {
        logic [M_TDATA_W-FAN_W-4:0] pad;
        logic                       night;
        logic                       critical;
        logic                       fan_written;
        logic [FAN_W-1:0]           fan_drive;
    } result_t;

endpackage

/* hw/rtl/gpu_fan_step_regulator.sv */
// Channel   | Direction | Bits  | Handshake
// s_axis    | in        | 16    | s_tvalid / s_tready
// m_axis    | out       | 16    | m_tvalid / m_tready
// cfg       | in        | 3 + 8 | cfg_we, no wait
//
// An item is registered on acceptance and worked out in the next cycle; its result is
// registered in result_reg and presented on m_tdata. One item is taken in every cycle
// while m_tready keeps up with the results.
// The per-card fan store is written in the same cycle as the result register, so the
// next item for the same card sees the updated value without any extra wait.
// aresetn is synchronous and active low; it empties both stages, loads the register
// defaults and sets every fan entry to 200.
// While a result waits on m_tready, one more item is still taken into the input stage.
`include "assert_macros.svh"

module gpu_fan_step_regulator #(
    parameter int unsigned NUM_CARDS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // card_index [2:0], temperature [10:3], hour [15:11]
    input  logic [gfsr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fan_drive [7:0], fan_written [8], critical [9], night [10], zero [15:11]
    output logic [gfsr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [gfsr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [gfsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import gfsr_pkg::*;

    localparam int unsigned DEPTH = (NUM_CARDS < (1 << CARD_W)) ? NUM_CARDS : (1 << CARD_W);
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SEL_W = (IDX_W > CARD_W) ? IDX_W : CARD_W;
    localparam logic [CARD_W:0] CARD_LIMIT = (CARD_W + 1)'(DEPTH);

    logic signed [TEMP_W-1:0] day_limit_reg;
    logic signed [TEMP_W-1:0] night_limit_reg;
    logic signed [TEMP_W-1:0] critical_limit_reg;
    logic [FAN_W-1:0]         day_min_fan_reg;
    logic [FAN_W-1:0]         night_min_fan_reg;

    logic [FAN_W-1:0] fan_store_reg [DEPTH];

    sample_t sample_reg;
    logic    sample_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;

    logic                     advance;
    logic                     card_ok;
    logic [SEL_W-1:0]         card_wide;
    logic [IDX_W-1:0]         addr;
    logic                     night;
    logic signed [TEMP_W-1:0] limit;
    logic [FAN_W-1:0]         min_fan;
    logic [FAN_W-1:0]         old_fan;
    logic                     crit;
    logic signed [TEMP_W:0]   err;
    logic signed [TEMP_W:0]   err_clamped;
    logic [TEMP_W:0]          mag;
    logic [TEMP_W:0]          step;
    logic [TEMP_W+1:0]        sum;
    logic [TEMP_W:0]          moved;
    logic [FAN_W-1:0]         new_fan;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !sample_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    always_comb begin
        card_ok   = {1'b0, sample_reg.card_index} < CARD_LIMIT;
        card_wide = SEL_W'(sample_reg.card_index);
        addr      = card_wide[IDX_W-1:0];
        night     = !((sample_reg.hour >= DAY_START_HOUR) &&
                      (sample_reg.hour < NIGHT_START_HOUR));
        limit     = night ? night_limit_reg : day_limit_reg;
        min_fan   = night ? night_min_fan_reg : day_min_fan_reg;
        old_fan   = fan_store_reg[addr];
        crit      = sample_reg.temperature > critical_limit_reg;

        err = (TEMP_W + 1)'(sample_reg.temperature) - (TEMP_W + 1)'(limit);
        err_clamped = (err < ERR_FLOOR) ? ERR_FLOOR : err;
        mag = err_clamped[TEMP_W] ? (TEMP_W + 1)'(-err_clamped) : err_clamped;
        step = mag >> 1;
        if (step == '0) begin
            step = (TEMP_W + 1)'(1);
        end
        if (err > 0 && mag > BOOST_THRESHOLD) begin
            step = step << 1;
        end

        sum   = (TEMP_W + 2)'(old_fan) + (TEMP_W + 2)'(step);
        moved = (TEMP_W + 1)'(old_fan);
        if (err > 0) begin
            moved = (sum > (TEMP_W + 2)'(FAN_MAX)) ? (TEMP_W + 1)'(FAN_MAX)
                                                   : sum[TEMP_W:0];
        end else if (err < 0) begin
            moved = ((TEMP_W + 1)'(old_fan) < step) ? '0
                                                    : (TEMP_W + 1)'(old_fan) - step;
        end

        new_fan = moved[FAN_W-1:0];
        if (crit) begin
            new_fan = FAN_MAX;
        end else if (new_fan < min_fan) begin
            new_fan = min_fan;
        end

        result_next       = '0;
        result_next.night = night;
        if (card_ok) begin
            result_next.fan_drive   = new_fan;
            result_next.critical    = crit;
            result_next.fan_written = crit || (new_fan != old_fan);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_limit_reg      <= DAY_LIMIT_RESET;
            night_limit_reg    <= NIGHT_LIMIT_RESET;
            critical_limit_reg <= CRITICAL_LIMIT_RESET;
            day_min_fan_reg    <= DAY_MIN_FAN_RESET;
            night_min_fan_reg  <= NIGHT_MIN_FAN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DAY_LIMIT:      day_limit_reg      <= cfg_wdata;
                REG_NIGHT_LIMIT:    night_limit_reg    <= cfg_wdata;
                REG_CRITICAL_LIMIT: critical_limit_reg <= cfg_wdata;
                REG_DAY_MIN_FAN:    day_min_fan_reg    <= cfg_wdata;
                REG_NIGHT_MIN_FAN:  night_min_fan_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                fan_store_reg[i] <= FAN_RESET;
            end
        end else if (advance && sample_valid_reg && card_ok) begin
            fan_store_reg[addr] <= new_fan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                sample_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= sample_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            sample_reg <= sample_t'(s_tdata);
        end
        if (advance && sample_valid_reg) begin
            result_reg <= result_next;
        end
    end

    `ASSERT_CLK(a_stall_only_on_full,
        !s_tready |-> (out_valid_reg && sample_valid_reg && !m_tready),
        "input stalled without a waiting result")

    `ASSERT_CLK(a_critical_full,
        (out_valid_reg && result_reg.critical) |->
            (result_reg.fan_drive == FAN_MAX && result_reg.fan_written),
        "critical item did not force full fan")

    `ASSERT_CLK(a_store_matches_result,
        (advance && sample_valid_reg && card_ok) |=>
            (fan_store_reg[$past(addr)] == result_reg.fan_drive),
        "fan store and result disagree")

    `ASSERT_CLK(a_pad_zero,
        result_reg.pad == '0 || !out_valid_reg,
        "result padding not zero")

endmodule
